### sv/flog_pkg.sv
// Shared types, constants and the header checksum for the flash ring log controller.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package flog_pkg;

   localparam int PAGE_BYTES_DEF = 512;
   localparam int DATA_PAGES_DEF = 15;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [31:0] LOG_MAGIC   = 32'h574C4F47;
   localparam logic [15:0] LOG_VERSION = 16'd1;
   localparam logic [7:0]  BLANK_BYTE  = 8'hFF;
   localparam logic [15:0] CSUM_SEED   = 16'hA55A;
   localparam logic [15:0] CSUM_MASK   = 16'h5A5A;

   // Seed plus the four magic bytes plus the version; the variable part of the
   // header sum is only write position, used count and sequence.
   localparam logic [15:0] HDR_BASE = 16'(32'(CSUM_SEED) + 32'(LOG_MAGIC[7:0])
      + 32'(LOG_MAGIC[15:8]) + 32'(LOG_MAGIC[23:16]) + 32'(LOG_MAGIC[31:24])
      + 32'(LOG_VERSION));

   // Request type codes on the input channel.
   localparam logic [2:0] REQ_APPEND  = 3'd0;
   localparam logic [2:0] REQ_COMMIT  = 3'd1;
   localparam logic [2:0] REQ_READ    = 3'd2;
   localparam logic [2:0] REQ_CLEAR   = 3'd3;
   localparam logic [2:0] REQ_RESTORE = 3'd4;

   typedef enum logic [2:0] {
      CMD_APPEND  = 3'd0,
      CMD_COMMIT  = 3'd1,
      CMD_READ    = 3'd2,
      CMD_CLEAR   = 3'd3,
      CMD_RESTORE = 3'd4,
      CMD_NOP     = 3'd5
   } cmd_op_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  data_byte;
      logic [12:0] read_index;
      logic [31:0] hdr_magic;
      logic [15:0] hdr_version;
      logic [15:0] hdr_write_offset;
      logic [15:0] hdr_used;
      logic [15:0] hdr_sequence;
      logic [15:0] hdr_checksum;
   } log_req_type;

   typedef struct packed {
      logic [7:0]  read_byte;
      logic        read_ok;
      logic        header_ok;
      logic        page_erased;
      logic [12:0] cur_write_offset;
      logic [12:0] cur_used;
      logic [15:0] cur_sequence;
      logic [15:0] cur_checksum;
   } log_rsp_type;

   // Classified request as it travels from the front end to the back end.
   typedef struct packed {
      cmd_op_type  op;
      logic [7:0]  data_byte;
      logic [12:0] read_index;
      logic        hdr_pass;
      logic [15:0] hdr_write_offset;
      logic [15:0] hdr_used;
      logic [15:0] hdr_sequence;
   } log_cmd_type;

   // Header checksum for the fixed magic and version.
   function automatic logic [15:0] hdr_sum(input logic [31:0] wpos,
                                           input logic [31:0] used,
                                           input logic [15:0] seq);
      logic [15:0] s;
      s = HDR_BASE + wpos[15:0] + used[15:0] + seq;
      return s ^ CSUM_MASK;
   endfunction

endpackage

### sv/flog_front.sv
// Front end: takes request transactions and classifies them into commands.
// Restore headers are checked here. Depends on flog_pkg.
`timescale 1ns / 1ps

module flog_front #(
   parameter int PAGE_BYTES = flog_pkg::PAGE_BYTES_DEF,
   parameter int DATA_PAGES = flog_pkg::DATA_PAGES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  flog_pkg::log_req_type  req_data,
   input  logic                   init_busy,
   output logic                   push_valid,
   input  logic                   push_ready,
   output flog_pkg::log_cmd_type  push_cmd
);
   import flog_pkg::*;

   localparam int LOG_BYTES = PAGE_BYTES * DATA_PAGES;

   logic        valid_ff, valid_in;
   log_cmd_type cmd_ff, cmd_in;
   logic        take;

   assign req_ready  = !init_busy && (!valid_ff || push_ready);
   assign take       = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   always_comb begin
      cmd_in                  = cmd_ff;
      cmd_in.data_byte        = req_data.data_byte;
      cmd_in.read_index       = req_data.read_index;
      cmd_in.hdr_write_offset = req_data.hdr_write_offset;
      cmd_in.hdr_used         = req_data.hdr_used;
      cmd_in.hdr_sequence     = req_data.hdr_sequence;
      unique case (req_data.req_type)
         REQ_APPEND:  cmd_in.op = CMD_APPEND;
         REQ_COMMIT:  cmd_in.op = CMD_COMMIT;
         REQ_READ:    cmd_in.op = CMD_READ;
         REQ_CLEAR:   cmd_in.op = CMD_CLEAR;
         REQ_RESTORE: cmd_in.op = CMD_RESTORE;
         default:     cmd_in.op = CMD_NOP;
      endcase
      // With magic and version matching, the supplied header sums the same way
      // as the one the block reports.
      cmd_in.hdr_pass = (req_data.hdr_magic == LOG_MAGIC)
         && (req_data.hdr_version == LOG_VERSION)
         && (32'(req_data.hdr_write_offset) < 32'(LOG_BYTES))
         && (32'(req_data.hdr_used) <= 32'(LOG_BYTES))
         && (req_data.hdr_checksum == hdr_sum(32'(req_data.hdr_write_offset),
                                              32'(req_data.hdr_used),
                                              req_data.hdr_sequence));
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

### sv/flog_queue.sv
// Short command queue between the front end and the back end.
// Depends on flog_pkg for the command type and depth.
`timescale 1ns / 1ps

module flog_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  flog_pkg::log_cmd_type  push_cmd,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output flog_pkg::log_cmd_type  pop_cmd
);
   import flog_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   log_cmd_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/flog_back.sv
// Back end: header state, the single-port log store and the sequencer that
// carries out commands, plus the result register. Depends on flog_pkg.
`timescale 1ns / 1ps

module flog_back #(
   parameter int PAGE_BYTES = flog_pkg::PAGE_BYTES_DEF,
   parameter int DATA_PAGES = flog_pkg::DATA_PAGES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  flog_pkg::log_cmd_type  pop_cmd,
   output logic                   init_busy,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output flog_pkg::log_rsp_type  rsp_data
);
   import flog_pkg::*;

   localparam int LOG_BYTES = PAGE_BYTES * DATA_PAGES;
   localparam int PTR_W     = $clog2(LOG_BYTES);
   localparam int CNT_W     = $clog2(LOG_BYTES + 1);
   localparam int SUM_W     = PTR_W + 1;

   typedef enum logic [6:0] {
      ST_INIT  = 7'b000_0001,
      ST_IDLE  = 7'b000_0010,
      ST_CHECK = 7'b000_0100,
      ST_ERASE = 7'b000_1000,
      ST_WRITE = 7'b001_0000,
      ST_RADDR = 7'b010_0000,
      ST_RDATA = 7'b100_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [15:0]       seq_ff, seq_in;
   logic [PTR_W-1:0]  sweep_ff, sweep_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic [7:0]        byte_ff, byte_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;
   logic [PTR_W-1:0]  start_ff, start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   log_rsp_type       rsp_ff, rsp_in;

   logic [7:0]        mem [LOG_BYTES];
   logic [7:0]        rdata_ff;
   logic              mem_we;
   logic [PTR_W-1:0]  mem_addr;
   logic [7:0]        mem_wdata;

   logic              out_free, take, at_boundary, load;
   logic [PTR_W-1:0]  wp_next, erase_last, raddr;
   logic [CNT_W-1:0]  used_sat_inc, used_page_drop;
   logic [SUM_W-1:0]  start_sum, raddr_sum;
   logic [7:0]        rsp_rb;
   logic              rsp_rok, rsp_hok, rsp_er;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE) && out_free;
   assign take      = pop_valid && pop_ready;
   assign init_busy = (state_ff == ST_INIT) && !clr_rsp_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A page starts at one of DATA_PAGES fixed offsets.
   always_comb begin
      at_boundary = 1'b0;
      for (int k = 0; k < DATA_PAGES; k++) begin
         at_boundary = at_boundary || (wp_ff == PTR_W'(k * PAGE_BYTES));
      end
   end

   assign wp_next        = (wp_ff == PTR_W'(LOG_BYTES - 1)) ? '0 : wp_ff + 1'b1;
   assign used_sat_inc   = (used_ff < CNT_W'(LOG_BYTES)) ? used_ff + 1'b1 : used_ff;
   assign used_page_drop = (used_ff > CNT_W'(PAGE_BYTES))
                           ? used_ff - CNT_W'(PAGE_BYTES) : '0;
   assign erase_last     = wp_ff + PTR_W'(PAGE_BYTES - 1);

   // Oldest byte sits at write position minus used count, modulo the log size.
   assign start_sum = SUM_W'(wp_ff) + SUM_W'(LOG_BYTES) - SUM_W'(used_ff);
   assign raddr_sum = SUM_W'(start_ff) + SUM_W'(idx_ff);
   assign raddr     = (raddr_sum >= SUM_W'(LOG_BYTES))
                      ? PTR_W'(raddr_sum - SUM_W'(LOG_BYTES)) : PTR_W'(raddr_sum);

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      used_in    = used_ff;
      seq_in     = seq_ff;
      sweep_in   = sweep_ff;
      clr_rsp_in = clr_rsp_ff;
      byte_in    = byte_ff;
      idx_in     = idx_ff;
      start_in   = start_ff;
      mem_we     = 1'b0;
      mem_addr   = wp_ff;
      mem_wdata  = byte_ff;
      load       = 1'b0;
      rsp_rb     = '0;
      rsp_rok    = 1'b0;
      rsp_hok    = 1'b0;
      rsp_er     = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_addr  = sweep_ff;
            mem_wdata = BLANK_BYTE;
            if (sweep_ff == PTR_W'(LOG_BYTES - 1)) begin
               load       = clr_rsp_ff;
               clr_rsp_in = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (take) begin
               byte_in = pop_cmd.data_byte;
               unique case (pop_cmd.op)
                  CMD_APPEND: begin
                     if (at_boundary) begin
                        // Look at the page's first byte before writing.
                        state_in = ST_CHECK;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = pop_cmd.data_byte;
                        wp_in     = wp_next;
                        used_in   = used_sat_inc;
                        load      = 1'b1;
                     end
                  end
                  CMD_COMMIT: begin
                     seq_in = seq_ff + 1'b1;
                     load   = 1'b1;
                  end
                  CMD_READ: begin
                     if (32'(pop_cmd.read_index) < 32'(used_ff)) begin
                        idx_in   = PTR_W'(pop_cmd.read_index);
                        start_in = (start_sum >= SUM_W'(LOG_BYTES))
                                   ? PTR_W'(start_sum - SUM_W'(LOG_BYTES))
                                   : PTR_W'(start_sum);
                        state_in = ST_RADDR;
                     end else begin
                        load = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     wp_in      = '0;
                     used_in    = '0;
                     seq_in     = '0;
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_INIT;
                  end
                  CMD_RESTORE: begin
                     if (pop_cmd.hdr_pass) begin
                        wp_in   = PTR_W'(pop_cmd.hdr_write_offset);
                        used_in = CNT_W'(pop_cmd.hdr_used);
                        seq_in  = pop_cmd.hdr_sequence;
                        rsp_hok = 1'b1;
                     end else begin
                        wp_in   = '0;
                        used_in = '0;
                        seq_in  = '0;
                     end
                     load = 1'b1;
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (rdata_ff != BLANK_BYTE) begin
               sweep_in = wp_ff;
               state_in = ST_ERASE;
            end else begin
               mem_we   = 1'b1;
               wp_in    = wp_next;
               used_in  = used_sat_inc;
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ERASE: begin
            mem_we    = 1'b1;
            mem_addr  = sweep_ff;
            mem_wdata = BLANK_BYTE;
            if (sweep_ff == erase_last) begin
               used_in  = used_page_drop;
               state_in = ST_WRITE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            wp_in    = wp_next;
            used_in  = used_sat_inc;
            rsp_er   = 1'b1;
            load     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_RADDR: begin
            mem_addr = raddr;
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            rsp_rb   = rdata_ff;
            rsp_rok  = 1'b1;
            load     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in                  = rsp_ff;
      rsp_in.read_byte        = rsp_rb;
      rsp_in.read_ok          = rsp_rok;
      rsp_in.header_ok        = rsp_hok;
      rsp_in.page_erased      = rsp_er;
      rsp_in.cur_write_offset = 13'(wp_in);
      rsp_in.cur_used         = 13'(used_in);
      rsp_in.cur_sequence     = seq_in;
      rsp_in.cur_checksum     = hdr_sum(32'(wp_in), 32'(used_in), seq_in);

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         wp_ff        <= '0;
         used_ff      <= '0;
         seq_ff       <= '0;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         used_ff      <= used_in;
         seq_ff       <= seq_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      idx_ff   <= idx_in;
      start_ff <= start_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Single-port log store with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_addr];
   end

endmodule

### sv/flash_ring_log_controller.sv
// Flash ring log controller: circular byte log with page erase, header commit,
// read, clear and header restore. Instantiates flog_front, flog_queue and
// flog_back; depends on flog_pkg.
//
// Usage: requests enter on req_valid/req_ready with payload req_data; one result
// per request leaves on rsp_valid/rsp_ready with payload rsp_data. A transaction
// completes on a rising edge with valid and ready both high.
// Commit, restore, ignored types, reads beyond the used count and appends off a
// page start are answered from the idle state; an append at a page start reads
// the page's first byte and erases the page first if that byte is not blank; a
// read passes an address and a data state; a clear sweeps the store to 0xFF first.
// The log store has one port: append and read bytes cost store cycles, erases run
// one byte per cycle. Short requests sustain one per cycle while rsp_ready is high.
// After reset the whole store, PAGE_BYTES * DATA_PAGES bytes (7680 by default), is
// swept to 0xFF while req_ready stays low.
// When rsp_ready is low the result waits in the output register; the front stage
// and the two-entry queue keep taking requests until they fill.
`timescale 1ns / 1ps

module flash_ring_log_controller #(
   parameter int PAGE_BYTES = flog_pkg::PAGE_BYTES_DEF,
   parameter int DATA_PAGES = flog_pkg::DATA_PAGES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  flog_pkg::log_req_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output flog_pkg::log_rsp_type  rsp_data
);
   import flog_pkg::*;

   logic        init_busy;
   logic        push_valid, push_ready;
   log_cmd_type push_cmd;
   logic        pop_valid, pop_ready;
   log_cmd_type pop_cmd;

   flog_front #(
      .PAGE_BYTES (PAGE_BYTES),
      .DATA_PAGES (DATA_PAGES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .init_busy  (init_busy),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   flog_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   flog_back #(
      .PAGE_BYTES (PAGE_BYTES),
      .DATA_PAGES (DATA_PAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
